// ===== src/slt_pkg.sv =====
// ============================================================================
// slt_pkg
// Shared types and codes for the sorted list table: request and status
// codes, the transaction token that walks the cell chain, and the
// controller state type.
// ============================================================================
package slt_pkg;

  // Default number of entries
  localparam int CAPACITY_DEF = 16;

  localparam int VALUE_W = 32;
  localparam int OUT_CNT_W = 5;

  // Request codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Transaction token handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] carry;  // entry pushed down by an insert
    logic                      flag;   // insert placed, or match seen
    logic                      full;   // table was full at entry
  } token_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } state_t;

endpackage

// ===== src/slt_cell.sv =====
// ============================================================================
// slt_cell
// One slot of the sorted list: holds one entry, applies the passing
// transaction token to it and hands the token to the next slot.
// ============================================================================
module slt_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic [CNT_W-1:0]                   count,
  input  logic signed [slt_pkg::VALUE_W-1:0] next_entry,
  input  slt_pkg::token_t                    tok_i,
  output slt_pkg::token_t                    tok_o,
  output logic signed [slt_pkg::VALUE_W-1:0] entry_o
);

  localparam logic [CNT_W-1:0] INDEX_C = CNT_W'(INDEX);

  logic signed [slt_pkg::VALUE_W-1:0] entry_r;
  logic signed [slt_pkg::VALUE_W-1:0] entry_nxt;
  slt_pkg::token_t                    tok_r;
  slt_pkg::token_t                    tok_nxt;
  logic                               occ;
  logic                               at_end;
  logic                               gt;
  logic                               eq;

  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_i;
    occ       = INDEX_C < count;
    at_end    = INDEX_C == count;
    gt        = entry_r > tok_i.value;
    eq        = entry_r == tok_i.value;
    if (tok_i.valid) begin
      case (tok_i.op)
        slt_pkg::OP_INSERT: begin
          if (!tok_i.full) begin
            if (occ) begin
              if (tok_i.flag) begin
                // ripple: swap carried entry with ours
                entry_nxt     = tok_i.carry;
                tok_nxt.carry = entry_r;
              end else if (!gt) begin
                entry_nxt     = tok_i.value;
                tok_nxt.carry = entry_r;
                tok_nxt.flag  = 1'b1;
              end
            end else if (at_end) begin
              entry_nxt = tok_i.flag ? tok_i.carry : tok_i.value;
            end
          end
        end
        slt_pkg::OP_DELETE: begin
          if (occ) begin
            if (tok_i.flag) begin
              entry_nxt = next_entry;
            end else if (eq) begin
              entry_nxt    = next_entry;
              tok_nxt.flag = 1'b1;
            end
          end
        end
        default: begin
          if (occ && eq) begin
            tok_nxt.flag = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_i.valid) begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o   = tok_r;
  assign entry_o = entry_r;

endmodule

// ===== src/sorted_list_table.sv =====
// ============================================================================
// sorted_list_table
// Bounded list of signed 32-bit values held in descending order. Each
// transaction inserts a value, deletes the first equal entry, or searches
// for a value, and returns a status and the entry count.
// ============================================================================
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | in_valid, in_stall, in_req_type, in_value | in
//  result   | out_valid, out_stall, out_status,       | out
//           | out_entry_count                         |
//
//  Timing: an accepted request becomes a token that walks the cell chain one
//  slot per cycle unless the chain is held, then loads the result register.
//  The next request is accepted in the cycle after the result is registered.
//  Reset: rst_n (synchronous, active low) empties the list and drops any
//  transaction in flight; entry contents are not cleared.
//  Stalls: a waiting result does not block a new request; only when the
//  token reaches the chain end while the result register is still held
//  does the whole chain hold.
//
module sorted_list_table #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_req_type,
  input  logic signed [slt_pkg::VALUE_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [slt_pkg::OUT_CNT_W-1:0]        out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  slt_pkg::state_t state_r;
  slt_pkg::state_t state_nxt;

  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic                               out_valid_r;
  logic [1:0]                         out_status_r;
  logic [slt_pkg::OUT_CNT_W-1:0]      out_entry_count_r;
  logic [1:0]                         status_nxt;
  logic [CNT_W+slt_pkg::OUT_CNT_W-1:0] cnt_ext;

  logic            advance;
  logic            accept;
  logic            finish;
  slt_pkg::token_t tok [CAPACITY+1];
  logic signed [slt_pkg::VALUE_W-1:0] ent [CAPACITY];

  // Hold the chain only when a finished token cannot enter the result register
  assign finish  = tok[CAPACITY].valid;
  assign advance = !(finish && out_valid_r && out_stall);
  assign accept  = in_valid && !in_stall;

  // Build the token for the first cell straight from the request
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept;
    tok[0].op    = in_req_type;
    tok[0].value = in_value;
    tok[0].full  = count_r >= CAP_C;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [slt_pkg::VALUE_W-1:0] next_entry;
    if (k == CAPACITY - 1) begin : g_last
      assign next_entry = ent[k];
    end else begin : g_mid
      assign next_entry = ent[k+1];
    end
    slt_cell #(
      .INDEX(k),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .count     (count_r),
      .next_entry(next_entry),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .entry_o   (ent[k])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = slt_pkg::S_RUN;
        end
      end
      slt_pkg::S_RUN: begin
        if (finish && advance) begin
          state_nxt = slt_pkg::S_IDLE;
        end
      end
      default: state_nxt = slt_pkg::S_IDLE;
    endcase
  end

  // Outputs of the controller: one transaction in the chain at a time
  always_comb begin
    case (state_r)
      slt_pkg::S_IDLE: in_stall = 1'b0;
      default:         in_stall = 1'b1;
    endcase
  end

  // Status and new count from the token leaving the chain
  always_comb begin
    count_nxt  = count_r;
    status_nxt = tok[CAPACITY].flag ? slt_pkg::ST_DONE : slt_pkg::ST_NOT_FOUND;
    case (tok[CAPACITY].op)
      slt_pkg::OP_INSERT: begin
        if (tok[CAPACITY].full) begin
          status_nxt = slt_pkg::ST_FULL;
        end else begin
          status_nxt = slt_pkg::ST_DONE;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      slt_pkg::OP_DELETE: begin
        if (tok[CAPACITY].flag) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
    cnt_ext = {{slt_pkg::OUT_CNT_W{1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish && advance) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load with the finishing token, hold otherwise
  always_ff @(posedge clk) begin
    if (finish && advance) begin
      out_status_r      <= status_nxt;
      out_entry_count_r <= cnt_ext[slt_pkg::OUT_CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

endmodule

// ===== src/slt_checker.sv =====
// ============================================================================
// slt_checker
// Port-level checks for the sorted list table, bound to the top level.
// ============================================================================
module slt_checker #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_status,
  input logic [slt_pkg::OUT_CNT_W-1:0] out_entry_count
);

  localparam logic [slt_pkg::OUT_CNT_W-1:0] CAP5 = slt_pkg::OUT_CNT_W'(CAPACITY);

  // One transaction at a time: an accept blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // No result can appear right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared before the chain was traversed");

  // A rejected insert reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == slt_pkg::ST_FULL) |-> out_entry_count == CAP5)
    else $error("full status with count below capacity");

  // Status codes only
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == slt_pkg::ST_DONE ||
                   out_status == slt_pkg::ST_NOT_FOUND ||
                   out_status == slt_pkg::ST_FULL))
    else $error("undefined status code");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_entry_count)))
    else $error("stalled result changed");

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);
